>>> hdl/pose_separation_filter_top_defines.svh
// ----------------------------------------------------------------------------
// pose_separation_filter_top_defines
// Assertion macros shared by the pose separation filter.
// Each use expands to one labeled concurrent assertion on i_clk.
// ----------------------------------------------------------------------------
`ifndef POSE_SEPARATION_FILTER_TOP_DEFINES_SVH
`define POSE_SEPARATION_FILTER_TOP_DEFINES_SVH

// Checked only while out of reset.
`define PSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PSF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hdl/psf_pkg.sv
// ----------------------------------------------------------------------------
// psf_pkg
// Types and constants of the pose separation filter.
// ----------------------------------------------------------------------------
package psf_pkg;

    // kept list depth and derived widths
    localparam int MAX_KEEP   = 16;
    localparam int KEEP_IDX_W = $clog2(MAX_KEEP);
    localparam int CNT_W      = $clog2(MAX_KEEP + 1);

    // field widths
    localparam int POS_W       = 24;
    localparam int HEAD_W      = 16;
    localparam int SEP_DIST_W  = 23;
    localparam int SEP_HEAD_W  = 16;
    localparam int KEEP_LIM_W  = 5;
    localparam int SLOT_W      = 4;
    localparam int CFG_DATA_W  = 23;
    localparam int CFG_ADDR_W  = 2;

    // squared distance widths
    localparam int DIFF_W = POS_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int LIM2_W = 2 * SEP_DIST_W;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SEP_DIST  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEP_HEAD  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEEP_LIM  = 2'd2;

    // register reset values
    localparam logic [SEP_DIST_W-1:0] SEP_DIST_RST = 23'd1024;
    localparam logic [SEP_HEAD_W-1:0] SEP_HEAD_RST = 16'd5461;
    localparam logic [KEEP_LIM_W-1:0] KEEP_LIM_RST = 5'd5;

    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [HEAD_W-1:0] h;
    } t_pose;

    // read request into the pose store
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [KEEP_IDX_W-1:0] addr;
    } t_rd_req;

    // tag that travels with read data
    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

    // compare result back to the sequencer
    typedef struct packed {
        logic valid;
        logic last;
        logic close;
    } t_cmp_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

endpackage

>>> hdl/psf_pose_store.sv
// ----------------------------------------------------------------------------
// psf_pose_store
// Kept pose memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module psf_pose_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [psf_pkg::KEEP_IDX_W-1:0] i_wr_addr,
    input  psf_pkg::t_pose                 i_wr_pose,
    input  psf_pkg::t_rd_req               i_rd_req,
    output psf_pkg::t_tag                  o_rd_tag,
    output psf_pkg::t_pose                 o_rd_pose
);
    import psf_pkg::*;

    t_pose mem [MAX_KEEP];
    t_pose r_rd_pose;
    t_tag  r_rd_tag;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_pose;
        end
    end

    // read port, data registered
    always_ff @(posedge i_clk) begin
        if (i_rd_req.valid) begin
            r_rd_pose <= mem[i_rd_req.addr];
        end
    end

    // tag is registered alongside the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_tag <= '0;
        end else begin
            r_rd_tag.valid <= i_rd_req.valid;
            r_rd_tag.last  <= i_rd_req.valid & i_rd_req.last;
        end
    end

    assign o_rd_tag  = r_rd_tag;
    assign o_rd_pose = r_rd_pose;

endmodule

>>> hdl/psf_compare_unit.sv
// ----------------------------------------------------------------------------
// psf_compare_unit
// Shared proximity test of the candidate against one kept pose per cycle.
// Two stages: squares and heading gap, then sum and threshold compare.
// ----------------------------------------------------------------------------
module psf_compare_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  psf_pkg::t_pose                 i_cand,
    input  psf_pkg::t_tag                  i_tag,
    input  psf_pkg::t_pose                 i_kept,
    input  logic [psf_pkg::SEP_DIST_W-1:0] i_sep_dist,
    input  logic [psf_pkg::SEP_HEAD_W-1:0] i_sep_head,
    output psf_pkg::t_cmp_rsp              o_rsp
);
    import psf_pkg::*;

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [SQ_W-1:0]   dx2;
    logic signed [SQ_W-1:0]   dy2;
    logic [HEAD_W-1:0]        hdiff;
    logic [HEAD_W:0]          hgap;
    logic [SQ_W-1:0]          dist2;

    logic [LIM2_W-1:0] r_lim2;
    logic [SQ_W-1:0]   r_dx2;
    logic [SQ_W-1:0]   r_dy2;
    logic              r_head_near;
    t_tag              r_tag;
    t_cmp_rsp          r_rsp;

    // squared threshold, refreshed every cycle from the register
    always_ff @(posedge i_clk) begin
        r_lim2 <= LIM2_W'(i_sep_dist * i_sep_dist);
    end

    // stage 1: differences, squares, wrapped heading gap
    always_comb begin
        dx    = DIFF_W'(i_cand.x) - DIFF_W'(i_kept.x);
        dy    = DIFF_W'(i_cand.y) - DIFF_W'(i_kept.y);
        dx2   = dx * dx;
        dy2   = dy * dy;
        hdiff = HEAD_W'(i_cand.h) - HEAD_W'(i_kept.h);
        // fold into half a turn; exactly pi stays at 32768
        if (hdiff[HEAD_W-1]) begin
            hgap = (HEAD_W+1)'(1 << HEAD_W) - {1'b0, hdiff};
        end else begin
            hgap = {1'b0, hdiff};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx2       <= dx2;
        r_dy2       <= dy2;
        r_head_near <= hgap < {1'b0, i_sep_head};
    end

    // stage 2: sum and compare
    assign dist2 = r_dx2 + r_dy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
            r_rsp <= '0;
        end else begin
            r_tag       <= i_tag;
            r_rsp.valid <= r_tag.valid;
            r_rsp.last  <= r_tag.last;
            r_rsp.close <= r_tag.valid & r_head_near
                           & (dist2 < SQ_W'(r_lim2));
        end
    end

    assign o_rsp = r_rsp;

endmodule

>>> hdl/pose_separation_filter_top.sv
// ----------------------------------------------------------------------------
// pose_separation_filter_top
// Greedy pose suppression with a keep limit, one candidate at a time.
// ----------------------------------------------------------------------------
// A candidate is taken when the block is idle and compared against the N
// poses kept so far, one kept pose per cycle through a single shared compare
// unit fed from the kept pose memory. A candidate that meets a full list, or
// the first one of a list, skips the scan and goes straight to write-back.
// Each kept pose is read through the single read port of the pose memory,
// registered, and then passed through the compare unit. A new request is
// accepted while the previous result still waits in the output register;
// the block only stalls at write-back until that result has been taken. The
// kept pose memory has no reset; only entries written in the current list
// are ever read.
`include "pose_separation_filter_top_defines.svh"

module pose_separation_filter_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [psf_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [psf_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // candidate stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [63:0]                    i_s_axis_tdata,  // pos_x, pos_y, heading
    input  logic                           i_s_axis_tuser,  // list_start
    // result stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [7:0]                     o_m_axis_tdata,  // slot, zero pad
    output logic [1:0]                     o_m_axis_tuser   // accepted, list_full
);
    import psf_pkg::*;

    // configuration registers
    logic [SEP_DIST_W-1:0] r_sep_dist;
    logic [SEP_HEAD_W-1:0] r_sep_head;
    logic [KEEP_LIM_W-1:0] r_keep_lim;

    // sequencer state
    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [KEEP_IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic                  r_ok, n_ok;
    logic                  r_close_any, n_close_any;
    t_pose                 r_cand, n_cand;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_acc, n_out_acc;
    logic [SLOT_W-1:0]     r_out_slot, n_out_slot;
    logic                  r_out_full, n_out_full;

    logic [CNT_W-1:0]      limit;
    logic [CNT_W-1:0]      start_count;
    logic                  s_accept;
    logic                  wr_en;
    logic                  keep;
    t_pose                 in_pose;
    t_rd_req               rd_req;
    t_tag                  rd_tag;
    t_pose                 rd_pose;
    t_cmp_rsp              cmp_rsp;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_dist <= SEP_DIST_RST;
            r_sep_head <= SEP_HEAD_RST;
            r_keep_lim <= KEEP_LIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SEP_DIST: r_sep_dist <= i_cfg_wdata[SEP_DIST_W-1:0];
                CFG_SEP_HEAD: r_sep_head <= i_cfg_wdata[SEP_HEAD_W-1:0];
                CFG_KEEP_LIM: r_keep_lim <= i_cfg_wdata[KEEP_LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // effective keep limit: zero acts as one, clamp at depth
    always_comb begin
        if (r_keep_lim == '0) begin
            limit = CNT_W'(1);
        end else if (int'(r_keep_lim) > MAX_KEEP) begin
            limit = CNT_W'(MAX_KEEP);
        end else begin
            limit = CNT_W'(r_keep_lim);
        end
    end

    assign in_pose.x = i_s_axis_tdata[POS_W-1:0];
    assign in_pose.y = i_s_axis_tdata[2*POS_W-1:POS_W];
    assign in_pose.h = i_s_axis_tdata[2*POS_W+HEAD_W-1:2*POS_W];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid & o_s_axis_tready;
    assign start_count     = i_s_axis_tuser ? '0 : r_count;
    assign keep            = r_ok & ~r_close_any;

    // sequencer: next state and outputs
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_ok        = r_ok;
        n_close_any = r_close_any | (cmp_rsp.valid & cmp_rsp.close);
        n_cand      = r_cand;
        n_out_valid = r_out_valid & ~i_m_axis_tready;
        n_out_acc   = r_out_acc;
        n_out_slot  = r_out_slot;
        n_out_full  = r_out_full;
        rd_req      = '0;
        wr_en       = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_cand      = in_pose;
                    n_count     = start_count;
                    n_ok        = start_count < limit;
                    n_close_any = 1'b0;
                    n_rd_idx    = '0;
                    if ((start_count < limit) && (start_count != '0)) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                // one kept pose read per cycle
                rd_req.valid = 1'b1;
                rd_req.addr  = r_rd_idx;
                rd_req.last  = (CNT_W'(r_rd_idx) == r_count - CNT_W'(1));
                n_rd_idx     = r_rd_idx + KEEP_IDX_W'(1);
                if (rd_req.last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (cmp_rsp.valid && cmp_rsp.last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // write back once the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_acc   = keep;
                    if (keep) begin
                        wr_en      = 1'b1;
                        n_count    = r_count + CNT_W'(1);
                        n_out_slot = SLOT_W'(r_count);
                    end else begin
                        n_out_slot = '0;
                    end
                    n_out_full = (keep ? r_count + CNT_W'(1) : r_count) >= limit;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // per-item working registers and result payload
    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_ok        <= n_ok;
        r_close_any <= n_close_any;
        r_cand      <= n_cand;
        r_out_acc   <= n_out_acc;
        r_out_slot  <= n_out_slot;
        r_out_full  <= n_out_full;
    end

    psf_pose_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[KEEP_IDX_W-1:0]),
        .i_wr_pose (r_cand),
        .i_rd_req  (rd_req),
        .o_rd_tag  (rd_tag),
        .o_rd_pose (rd_pose)
    );

    psf_compare_unit u_cmp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cand     (r_cand),
        .i_tag      (rd_tag),
        .i_kept     (rd_pose),
        .i_sep_dist (r_sep_dist),
        .i_sep_head (r_sep_head),
        .o_rsp      (cmp_rsp)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(8-SLOT_W){1'b0}}, r_out_slot};
    assign o_m_axis_tuser  = {r_out_full, r_out_acc};

    // a pose is only stored into a free slot below the limit
    `PSF_ASSERT(a_wr_below_limit, wr_en |-> (r_count < limit), "write at or past keep limit")
    // each stored pose advances the count by one
    `PSF_ASSERT(a_wr_count_step, wr_en |=> (r_count == $past(r_count) + CNT_W'(1)), "count not stepped")
    // compare results only come back while an item is being scanned
    `PSF_ASSERT(a_rsp_in_scan, cmp_rsp.valid |-> (r_state == ST_SCAN || r_state == ST_DRAIN), "stray compare result")
    // the count never exceeds the list depth
    `PSF_ASSERT(a_count_range, (r_count <= CNT_W'(MAX_KEEP)), "kept count out of range")

endmodule

>>> bench/pose_separation_filter_top_test.sv
// ----------------------------------------------------------------------------
// pose_separation_filter_top_test
// Self-checking bench for the pose separation filter.
// ----------------------------------------------------------------------------
// Candidates go in on the slave stream, verdicts come back on the master
// stream. A short directed table covers reset settings, coordinate and
// heading extremes, the exact distance and half-turn boundaries, keep limit
// saturation, zero limit and mid-list limit changes. Random phases follow,
// each with fresh register settings and mostly well-formed lists of poses
// placed near earlier ones. Each verdict is checked against its typed value
// or the in-bench suppression model; both streams idle and stall at random.
module pose_separation_filter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import psf_pkg::*;

    localparam int RANDOM_POSES  = 1850;
    localparam int IDLE_PCT      = 24;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int CALM_FROM     = 700;
    localparam int CALM_TO       = 1000;
    localparam int HIST_DEPTH    = 20;

    typedef struct packed {
        logic              accepted;
        logic [SLOT_W-1:0] slot;
        logic              list_full;
    } t_verdict;

    // verdict typed into the directed table, or none
    typedef struct {
        logic     pinned;
        t_verdict v;
    } t_pinned_verdict;

    typedef struct {
        logic                    is_reg;
        logic [CFG_ADDR_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]   val;
        logic                    start;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [HEAD_W-1:0] h;
        logic                    pinned;
        t_verdict                v;
    } t_step_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [63:0]           i_s_axis_tdata = '0;  // pos_x, pos_y, heading
    logic                  i_s_axis_tuser = 1'b0; // list_start
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [7:0]            o_m_axis_tdata;       // slot, zero pad
    logic [1:0]            o_m_axis_tuser;       // accepted, list_full

    // model state: kept poses and register copies
    logic signed [POS_W-1:0]  kept_px [MAX_KEEP];
    logic signed [POS_W-1:0]  kept_py [MAX_KEEP];
    logic signed [HEAD_W-1:0] kept_ph [MAX_KEEP];
    int                       kept_n = 0;
    logic [SEP_DIST_W-1:0]    sep_dist = SEP_DIST_RST;
    logic [SEP_HEAD_W-1:0]    sep_head = SEP_HEAD_RST;
    logic [KEEP_LIM_W-1:0]    keep_lim = KEEP_LIM_RST;

    t_verdict        verdict_q [$];
    t_pinned_verdict pinned_q [$];
    t_step_row       steps [$];

    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          calm = 1'b0;
    int          stall_left = 0;

    pose_separation_filter_top dut (.*);

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // greedy suppression rule; updates the kept list like the block does
    function automatic t_verdict admit_pose(logic start, logic signed [POS_W-1:0] x,
                                            logic signed [POS_W-1:0] y,
                                            logic signed [HEAD_W-1:0] h);
        int              limit;
        int              i;
        int              gap;
        logic            ok;
        longint          dx;
        longint          dy;
        longint          dist2;
        longint          lim2;
        logic [HEAD_W-1:0] hd;
        t_verdict        v;
        if (keep_lim == 0)
            limit = 1;
        else if (int'(keep_lim) > MAX_KEEP)
            limit = MAX_KEEP;
        else
            limit = int'(keep_lim);
        if (start)
            kept_n = 0;
        ok = (kept_n < limit);
        lim2 = longint'(sep_dist) * longint'(sep_dist);
        for (i = 0; i < kept_n; i++) begin
            dx = longint'(x) - longint'(kept_px[i]);
            dy = longint'(y) - longint'(kept_py[i]);
            dist2 = dx * dx + dy * dy;
            // heading gap wrapped to (-pi, pi], magnitude only
            hd = h - kept_ph[i];
            gap = (hd >= 16'd32768) ? 65536 - int'(hd) : int'(hd);
            if (dist2 < lim2 && gap < int'(sep_head))
                ok = 1'b0;
        end
        v.accepted = ok;
        v.slot = '0;
        if (ok) begin
            kept_px[kept_n] = x;
            kept_py[kept_n] = y;
            kept_ph[kept_n] = h;
            v.slot = kept_n[SLOT_W-1:0];
            kept_n++;
        end
        v.list_full = (kept_n >= limit);
        return v;
    endfunction

    // watch both streams and the register port
    always @(posedge i_clk) begin : watch
        t_verdict        predicted;
        t_verdict        want;
        t_pinned_verdict typed;
        if (!i_rst_n) begin
            kept_n = 0;
            sep_dist = SEP_DIST_RST;
            sep_head = SEP_HEAD_RST;
            keep_lim = KEEP_LIM_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SEP_DIST: sep_dist = i_cfg_wdata[SEP_DIST_W-1:0];
                    CFG_SEP_HEAD: sep_head = i_cfg_wdata[SEP_HEAD_W-1:0];
                    CFG_KEEP_LIM: keep_lim = i_cfg_wdata[KEEP_LIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predicted = admit_pose(i_s_axis_tuser, i_s_axis_tdata[23:0],
                                       i_s_axis_tdata[47:24], i_s_axis_tdata[63:48]);
                typed = pinned_q.pop_front();
                verdict_q.insert(verdict_q.size(), typed.pinned ? typed.v : predicted);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (verdict_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected verdict acc=%0d slot=%0d full=%0d", $time,
                             o_m_axis_tuser[0], o_m_axis_tdata[SLOT_W-1:0], o_m_axis_tuser[1]);
                end else begin
                    want = verdict_q.pop_front();
                    if (o_m_axis_tuser[0] !== want.accepted) begin
                        mismatch_count++;
                        $display("%0t: accepted expected %0d got %0d", $time,
                                 want.accepted, o_m_axis_tuser[0]);
                    end
                    if (o_m_axis_tdata[SLOT_W-1:0] !== want.slot) begin
                        mismatch_count++;
                        $display("%0t: slot expected %0d got %0d", $time,
                                 want.slot, o_m_axis_tdata[SLOT_W-1:0]);
                    end
                    if (o_m_axis_tuser[1] !== want.list_full) begin
                        mismatch_count++;
                        $display("%0t: list_full expected %0d got %0d", $time,
                                 want.list_full, o_m_axis_tuser[1]);
                    end
                end
            end
        end
    end

    // result side ready: random idling, occasional long stall, calm stretch
    always @(posedge i_clk) begin
        if (calm) begin
            i_m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            if ($urandom_range(199) == 0)
                stall_left <= $urandom_range(5, 40);
            i_m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("pose_separation_filter_top_test: done, errors");
        $finish;
    end

    function automatic void add_pose(logic start, logic signed [POS_W-1:0] x,
                                     logic signed [POS_W-1:0] y,
                                     logic signed [HEAD_W-1:0] h);
        t_step_row r;
        r = '{is_reg: 1'b0, idx: '0, val: '0, start: start, x: x, y: y, h: h,
              pinned: 1'b0, v: '0};
        steps.insert(steps.size(), r);
    endfunction

    function automatic void add_pinned(logic start, logic signed [POS_W-1:0] x,
                                       logic signed [POS_W-1:0] y,
                                       logic signed [HEAD_W-1:0] h,
                                       logic acc, logic [SLOT_W-1:0] slot, logic full);
        t_step_row r;
        r = '{is_reg: 1'b0, idx: '0, val: '0, start: start, x: x, y: y, h: h,
              pinned: 1'b1, v: '{acc, slot, full}};
        steps.insert(steps.size(), r);
    endfunction

    function automatic void add_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_step_row r;
        r = '{is_reg: 1'b1, idx: idx, val: val, start: 1'b0, x: '0, y: '0, h: '0,
              pinned: 1'b0, v: '0};
        steps.insert(steps.size(), r);
    endfunction

    // one candidate request, with a random gap in front
    task automatic offer_pose(logic start, logic signed [POS_W-1:0] x,
                              logic signed [POS_W-1:0] y, logic signed [HEAD_W-1:0] h,
                              logic pinned, t_verdict v);
        t_pinned_verdict t;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        t.pinned = pinned;
        t.v = v;
        pinned_q.insert(pinned_q.size(), t);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {h, y, x};
        i_s_axis_tuser <= start;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
    endtask

    // stop sending and let every outstanding verdict come back
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        int          done;
        int          list_left;
        int          phase_len;
        int          r;
        int          k;
        int          sgn;
        int          spread;
        int          hspread;
        int          sum;
        int          cur_dist;
        int          cur_head;
        int          hist_x [$];
        int          hist_y [$];
        int          hist_h [$];
        logic [31:0] bits;
        logic        st;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic [HEAD_W-1:0] ph;

        // directed table, starting from reset settings (1024, 5461, 5)
        add_pinned(1'b1, 24'sd0, 24'sd0, 16'sd0, 1'b1, 4'd0, 1'b0);
        add_pinned(1'b0, 24'sd100, 24'sd100, 16'sd100, 1'b0, 4'd0, 1'b0);
        // heading exactly half a turn away
        add_pinned(1'b0, 24'sd0, 24'sd0, -16'sd32768, 1'b1, 4'd1, 1'b0);
        add_pinned(1'b0, 24'sd8388607, 24'sd8388607, 16'sd32767, 1'b1, 4'd2, 1'b0);
        add_pinned(1'b0, -24'sd8388608, -24'sd8388608, -16'sd32768, 1'b1, 4'd3, 1'b0);
        // distance exactly at the threshold is not close; list fills
        add_pinned(1'b0, 24'sd1024, 24'sd0, 16'sd0, 1'b1, 4'd4, 1'b1);
        add_pinned(1'b0, 24'sd5000, 24'sd5000, 16'sd0, 1'b0, 4'd0, 1'b1);
        // limit raised mid-list: accepting resumes
        add_reg(CFG_KEEP_LIM, 23'd8);
        add_pinned(1'b0, 24'sd5000, 24'sd5000, 16'sd0, 1'b1, 4'd5, 1'b0);
        // limit lowered below the count: full
        add_reg(CFG_KEEP_LIM, 23'd3);
        add_pinned(1'b0, -24'sd5000, -24'sd5000, 16'sd0, 1'b0, 4'd0, 1'b1);
        // zero limit acts as one
        add_reg(CFG_KEEP_LIM, 23'd0);
        add_pinned(1'b1, 24'sd10, 24'sd10, 16'sd10, 1'b1, 4'd0, 1'b1);
        add_pinned(1'b0, 24'sd100000, 24'sd0, 16'sd0, 1'b0, 4'd0, 1'b1);
        // limit above depth saturates; zero distance makes nothing close
        add_reg(CFG_KEEP_LIM, 23'd31);
        add_reg(CFG_SEP_DIST, 23'd0);
        add_pinned(1'b1, 24'sd0, 24'sd0, 16'sd0, 1'b1, 4'd0, 1'b0);
        add_pinned(1'b0, 24'sd0, 24'sd0, 16'sd0, 1'b1, 4'd1, 1'b0);
        // widest distance, zero heading threshold
        add_reg(CFG_SEP_DIST, 23'd8388607);
        add_reg(CFG_SEP_HEAD, 23'd0);
        add_pinned(1'b0, 24'sd0, 24'sd0, 16'sd0, 1'b1, 4'd2, 1'b0);
        add_reg(CFG_SEP_HEAD, 23'd32768);
        add_pose(1'b0, 24'sd8388607, -24'sd8388608, 16'sd12345);
        add_pose(1'b0, 24'sd0, 24'sd0, -16'sd32768);
        add_reg(CFG_SEP_HEAD, 23'd65535);
        add_pose(1'b0, 24'sd1, 24'sd1, -16'sd32768);
        add_pose(1'b0, -24'sd1, 24'sd0, 16'sd32767);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[n]) begin
            if (steps[n].is_reg) begin
                if (n == 0 || !steps[n-1].is_reg)
                    wait_drained();
                set_reg(steps[n].idx, steps[n].val);
            end else begin
                offer_pose(steps[n].start, steps[n].x, steps[n].y, steps[n].h,
                           steps[n].pinned, steps[n].v);
            end
        end

        // random phases, each with new settings
        done = 0;
        list_left = 0;
        while (done < RANDOM_POSES) begin
            wait_drained();
            case ($urandom_range(9))
                0:       cur_dist = 0;
                1:       cur_dist = 8388607;
                2:       cur_dist = $urandom_range(0, 8388607);
                default: cur_dist = $urandom_range(1, 4096);
            endcase
            case ($urandom_range(7))
                0:       cur_head = 0;
                1:       cur_head = 32768;
                2:       cur_head = 65535;
                3:       cur_head = $urandom_range(0, 65535);
                default: cur_head = $urandom_range(1, 12000);
            endcase
            set_reg(CFG_SEP_DIST, cur_dist[CFG_DATA_W-1:0]);
            set_reg(CFG_SEP_HEAD, cur_head[CFG_DATA_W-1:0]);
            case ($urandom_range(6))
                0:       bits = 0;
                1:       bits = 31;
                2:       bits = 16;
                3:       bits = $urandom_range(0, 31);
                default: bits = $urandom_range(1, 16);
            endcase
            set_reg(CFG_KEEP_LIM, bits[CFG_DATA_W-1:0]);

            phase_len = $urandom_range(40, 120);
            repeat (phase_len) begin
                calm = (done >= CALM_FROM && done < CALM_TO);
                r = $urandom_range(99);
                if (list_left == 0) begin
                    st = 1'b1;
                    list_left = $urandom_range(1, 24);
                end else begin
                    st = 1'b0;
                end
                list_left--;
                if (r < 8) begin
                    // noise: any start flag, any bits
                    bits = $urandom;
                    st = bits[31];
                    px = bits[POS_W-1:0];
                    bits = $urandom;
                    py = bits[POS_W-1:0];
                    ph = bits[31:16];
                end else if (hist_x.size() != 0 && r < 25) begin
                    // right at the thresholds of an earlier pose
                    k = $urandom_range(hist_x.size() - 1);
                    sgn = $urandom_range(1) ? 1 : -1;
                    sum = hist_x[k] + sgn * (cur_dist - int'($urandom_range(1)));
                    px = sum[POS_W-1:0];
                    sum = hist_y[k];
                    py = sum[POS_W-1:0];
                    sum = hist_h[k] + sgn * (cur_head - int'($urandom_range(1)));
                    ph = sum[HEAD_W-1:0];
                end else if (hist_x.size() != 0 && r < 65) begin
                    // near an earlier pose
                    k = $urandom_range(hist_x.size() - 1);
                    spread = 2 * cur_dist + 2;
                    hspread = 2 * cur_head + 2;
                    sum = hist_x[k] + int'($urandom_range(0, 2 * spread)) - spread;
                    px = sum[POS_W-1:0];
                    sum = hist_y[k] + int'($urandom_range(0, 2 * spread)) - spread;
                    py = sum[POS_W-1:0];
                    sum = hist_h[k] + int'($urandom_range(0, 2 * hspread)) - hspread;
                    ph = sum[HEAD_W-1:0];
                end else if (r < 85) begin
                    // clustered around the origin
                    spread = 4 * cur_dist + 64;
                    sum = int'($urandom_range(0, 2 * spread)) - spread;
                    px = sum[POS_W-1:0];
                    sum = int'($urandom_range(0, 2 * spread)) - spread;
                    py = sum[POS_W-1:0];
                    bits = $urandom;
                    ph = bits[HEAD_W-1:0];
                end else begin
                    bits = $urandom;
                    px = bits[POS_W-1:0];
                    bits = $urandom;
                    py = bits[POS_W-1:0];
                    ph = bits[31:16];
                end
                offer_pose(st, px, py, ph, 1'b0, '0);
                done++;
                if (st) begin
                    hist_x.delete();
                    hist_y.delete();
                    hist_h.delete();
                end
                hist_x.insert(hist_x.size(), int'($signed(px)));
                hist_y.insert(hist_y.size(), int'($signed(py)));
                hist_h.insert(hist_h.size(), int'($signed(ph)));
                if (hist_x.size() > HIST_DEPTH) begin
                    hist_x.pop_front();
                    hist_y.pop_front();
                    hist_h.pop_front();
                end
            end
        end
        calm = 1'b0;

        wait_drained();
        if (mismatch_count == 0)
            $display("pose_separation_filter_top_test: done, clean");
        else
            $display("pose_separation_filter_top_test: done, errors");
        $finish;
    end

endmodule
